// ===== design/lrns_pkg.sv =====
// Shared widths, codes and structs for the letterbox rotate nearest scaler.
// No dependencies; every other design file refers to this package by scoped name.
package lrns_pkg;

   localparam int DIM_W     = 12;               // size and coordinate registers
   localparam int PIX_W     = 8;                // gray pixel
   localparam int WADDR_W   = 19;               // write address field
   localparam int LADDR_W   = 2 * DIM_W;        // linear source address, full range
   localparam int RECIP_K   = 24;               // reciprocal fraction bits
   localparam int RECIP_W   = RECIP_K + 1;      // reciprocal of one needs one more bit
   localparam int CSR_IDX_W = 2;
   localparam int DIV_CNT_W = $clog2(RECIP_W + 1);

   localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1) << RECIP_K;
   localparam logic [PIX_W-1:0]   WHITE     = 8'hFF;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic [DIM_W-1:0] SRC_W_RESET  = 12'd640;
   localparam logic [DIM_W-1:0] SRC_H_RESET  = 12'd480;
   localparam logic [DIM_W-1:0] DISP_W_RESET = 12'd1072;
   localparam logic [DIM_W-1:0] DISP_H_RESET = 12'd1448;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH   = 2'd0,
      CSR_SOURCE_HEIGHT  = 2'd1,
      CSR_DISPLAY_WIDTH  = 2'd2,
      CSR_DISPLAY_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      G_SETUP,
      G_DIV_P,
      G_DIV_RW,
      G_DIV_RH,
      G_DONE
   } geom_state_type;

   typedef struct packed {
      logic [DIM_W-1:0] sw;
      logic [DIM_W-1:0] sh;
      logic [DIM_W-1:0] dw;
      logic [DIM_W-1:0] dh;
   } csr_regs_type;

   typedef struct packed {
      logic               ready;
      logic               empty;
      logic               rot;
      logic [DIM_W-1:0]   ew;
      logic [DIM_W-1:0]   eh;
      logic [DIM_W-1:0]   pw;
      logic [DIM_W-1:0]   ph;
      logic [DIM_W-1:0]   ox;
      logic [DIM_W-1:0]   oy;
      logic [RECIP_W-1:0] rw;
      logic [RECIP_W-1:0] rh;
   } geom_type;

endpackage

// ===== design/lrns_if.sv =====
// Valid/ready channel interfaces for request, response and register write.
// Depends on lrns_pkg for field widths.
interface lrns_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [lrns_pkg::WADDR_W-1:0]  write_address;
   logic [lrns_pkg::PIX_W-1:0]    write_value;
   logic [lrns_pkg::DIM_W-1:0]    display_x;
   logic [lrns_pkg::DIM_W-1:0]    display_y;

   modport source (output valid, func, write_address, write_value, display_x, display_y,
                   input ready);
   modport sink   (input valid, func, write_address, write_value, display_x, display_y,
                   output ready);
endinterface

interface lrns_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lrns_pkg::PIX_W-1:0]  pixel_value;
   logic                        in_picture;

   modport source (output valid, pixel_value, in_picture, input ready);
   modport sink   (input valid, pixel_value, in_picture, output ready);
endinterface

interface lrns_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lrns_pkg::CSR_IDX_W-1:0]  index;
   logic [lrns_pkg::DIM_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/letterbox_rotate_nearest_scaler.sv =====
// Top level of the letterbox rotate nearest scaler: source frame memory, register
// file and the seven-stage coordinate pipeline. Depends on lrns_pkg, lrns_if, lrns_geom.
//
// The block takes one transaction per clock while the geometry is ready and nothing
// stalls, writes and reads freely mixed, and answers each one in order from the stage 6
// register; the single-port frame memory does one access per cycle in a fixed stage, so a
// read always sees every earlier write. The response register is followed by no extra
// storage: when the response side stalls, bubbles still in the pipeline keep accepting
// until it is full. After reset and after every register write the picture geometry is
// recomputed by a shared bit-serial divider, and no transaction is accepted meanwhile.
// Per pixel, the floor divisions by the picture size are exact reciprocal
// multiplies with one correction step.
module letterbox_rotate_nearest_scaler #(
   parameter int MAX_SOURCE_PIXELS = 524288
) (
   input  logic    clock,
   input  logic    reset,
   lrns_req_if.sink   req,
   lrns_rsp_if.source rsp,
   lrns_csr_if.sink   csr
);

   localparam int AW    = $clog2(MAX_SOURCE_PIXELS);
   localparam int NSTG  = 7;
   localparam logic [lrns_pkg::LADDR_W-1:0] MAX_ADDR = lrns_pkg::LADDR_W'(MAX_SOURCE_PIXELS);

   localparam int DW = lrns_pkg::DIM_W;
   localparam int PW = lrns_pkg::PIX_W;
   localparam int LW = lrns_pkg::LADDR_W;

   lrns_pkg::csr_regs_type cfg_ff;
   lrns_pkg::geom_type     geom;
   logic                   restart_ff;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] adv;
   logic            req_fire;

   // stage 0: captured request
   logic                            func0_ff;
   logic [lrns_pkg::WADDR_W-1:0]    waddr0_ff;
   logic [PW-1:0]                   wval0_ff;
   logic [DW-1:0]                   x0_ff, y0_ff;
   // stage 1: picture-relative coordinates
   logic                            func1_ff, inside1_ff;
   logic [lrns_pkg::WADDR_W-1:0]    waddr1_ff;
   logic [PW-1:0]                   wval1_ff;
   logic [DW-1:0]                   u1_ff, v1_ff, u_in, v_in;
   logic                            inside_in;
   // stage 2: numerators
   logic                            func2_ff, inside2_ff;
   logic [lrns_pkg::WADDR_W-1:0]    waddr2_ff;
   logic [PW-1:0]                   wval2_ff;
   logic [LW-1:0]                   nu2_ff, nv2_ff, nu_in, nv_in;
   // stage 3: quotient estimates
   logic                            func3_ff, inside3_ff;
   logic [lrns_pkg::WADDR_W-1:0]    waddr3_ff;
   logic [PW-1:0]                   wval3_ff;
   logic [LW-1:0]                   nu3_ff, nv3_ff;
   logic [LW+lrns_pkg::RECIP_W-1:0] pu_in, pv_in;
   logic [DW-1:0]                   qu3_ff, qv3_ff;
   // stage 4: source coordinates
   logic                            func4_ff, inside4_ff;
   logic [lrns_pkg::WADDR_W-1:0]    waddr4_ff;
   logic [PW-1:0]                   wval4_ff;
   logic [LW-1:0]                   ru_in, rv_in;
   logic [DW-1:0]                   rx_in, ry_in, rx4_ff, ry4_ff;
   // stage 5: linear address
   logic                            func5_ff, inside5_ff, inrange5_ff;
   logic [PW-1:0]                   wval5_ff;
   logic [LW-1:0]                   addr5_ff, addr_in, addr_mul;
   logic [DW-1:0]                   sx_in, sy_in;
   // stage 6: memory data
   logic                            func6_ff, inside6_ff, inrange6_ff;
   logic [PW-1:0]                   rd6_ff;
   logic                            mem_we;

   logic [PW-1:0] mem [MAX_SOURCE_PIXELS];

   lrns_geom u_geom (
      .clock   (clock),
      .reset   (reset),
      .restart (restart_ff),
      .cfg     (cfg_ff),
      .geom    (geom)
   );

   // register file
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sw  <= lrns_pkg::SRC_W_RESET;
         cfg_ff.sh  <= lrns_pkg::SRC_H_RESET;
         cfg_ff.dw  <= lrns_pkg::DISP_W_RESET;
         cfg_ff.dh  <= lrns_pkg::DISP_H_RESET;
         restart_ff <= 1'b0;
      end else begin
         restart_ff <= csr.valid;
         if (csr.valid) begin
            unique case (lrns_pkg::csr_index_type'(csr.index))
               lrns_pkg::CSR_SOURCE_WIDTH:   cfg_ff.sw <= csr.data;
               lrns_pkg::CSR_SOURCE_HEIGHT:  cfg_ff.sh <= csr.data;
               lrns_pkg::CSR_DISPLAY_WIDTH:  cfg_ff.dw <= csr.data;
               lrns_pkg::CSR_DISPLAY_HEIGHT: cfg_ff.dh <= csr.data;
            endcase
         end
      end
   end

   // a stage loads when it is empty or its contents move on
   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || rsp.ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req.ready = adv[0] && geom.ready && !restart_ff && !csr.valid;
   assign req_fire  = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_fire;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // stage datapath
   always_comb begin
      u_in      = x0_ff - geom.ox;
      v_in      = y0_ff - geom.oy;
      inside_in = !geom.empty && (x0_ff >= geom.ox) && (y0_ff >= geom.oy)
                  && (u_in < geom.pw) && (v_in < geom.ph);

      nu_in = u1_ff * geom.ew;
      nv_in = v1_ff * geom.eh;

      pu_in = nu2_ff * geom.rw;
      pv_in = nv2_ff * geom.rh;

      // estimate is the quotient or one short of it
      ru_in = nu3_ff - qu3_ff * geom.pw;
      rv_in = nv3_ff - qv3_ff * geom.ph;
      rx_in = (ru_in >= LW'(geom.pw)) ? qu3_ff + 1'b1 : qu3_ff;
      ry_in = (rv_in >= LW'(geom.ph)) ? qv3_ff + 1'b1 : qv3_ff;

      if (geom.rot) begin
         sx_in = ry4_ff;
         sy_in = cfg_ff.sh - DW'(1) - rx4_ff;
      end else begin
         sx_in = rx4_ff;
         sy_in = ry4_ff;
      end
      addr_mul = sy_in * cfg_ff.sw;
      if (func4_ff == lrns_pkg::FUNC_READ) begin
         addr_in = addr_mul + LW'(sx_in);
      end else begin
         addr_in = LW'(waddr4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0] && req_fire) begin
         func0_ff  <= req.func;
         waddr0_ff <= req.write_address;
         wval0_ff  <= req.write_value;
         x0_ff     <= req.display_x;
         y0_ff     <= req.display_y;
      end
      if (adv[1]) begin
         func1_ff   <= func0_ff;
         waddr1_ff  <= waddr0_ff;
         wval1_ff   <= wval0_ff;
         u1_ff      <= u_in;
         v1_ff      <= v_in;
         inside1_ff <= inside_in;
      end
      if (adv[2]) begin
         func2_ff   <= func1_ff;
         waddr2_ff  <= waddr1_ff;
         wval2_ff   <= wval1_ff;
         inside2_ff <= inside1_ff;
         nu2_ff     <= nu_in;
         nv2_ff     <= nv_in;
      end
      if (adv[3]) begin
         func3_ff   <= func2_ff;
         waddr3_ff  <= waddr2_ff;
         wval3_ff   <= wval2_ff;
         inside3_ff <= inside2_ff;
         nu3_ff     <= nu2_ff;
         nv3_ff     <= nv2_ff;
         qu3_ff     <= pu_in[lrns_pkg::RECIP_K +: DW];
         qv3_ff     <= pv_in[lrns_pkg::RECIP_K +: DW];
      end
      if (adv[4]) begin
         func4_ff   <= func3_ff;
         waddr4_ff  <= waddr3_ff;
         wval4_ff   <= wval3_ff;
         inside4_ff <= inside3_ff;
         rx4_ff     <= rx_in;
         ry4_ff     <= ry_in;
      end
      if (adv[5]) begin
         func5_ff    <= func4_ff;
         wval5_ff    <= wval4_ff;
         inside5_ff  <= inside4_ff;
         addr5_ff    <= addr_in;
         inrange5_ff <= (addr_in < MAX_ADDR);
      end
      if (adv[6]) begin
         func6_ff    <= func5_ff;
         inside6_ff  <= inside5_ff;
         inrange6_ff <= inrange5_ff;
      end
   end

   // frame memory: one access per cycle as the item leaves stage 5
   assign mem_we = adv[6] && vld_ff[5] && (func5_ff == lrns_pkg::FUNC_WRITE) && inrange5_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr5_ff[AW-1:0]] <= wval5_ff;
      end
      if (adv[6]) begin
         rd6_ff <= mem[addr5_ff[AW-1:0]];
      end
   end

   // response
   always_comb begin
      rsp.valid      = vld_ff[NSTG-1];
      rsp.in_picture = (func6_ff == lrns_pkg::FUNC_READ) && inside6_ff;
      if (func6_ff == lrns_pkg::FUNC_WRITE) begin
         rsp.pixel_value = '0;
      end else if (inside6_ff && inrange6_ff) begin
         rsp.pixel_value = rd6_ff;
      end else begin
         rsp.pixel_value = lrns_pkg::WHITE;
      end
   end

endmodule

// ===== design/lrns_geom.sv =====
// Picture geometry: orientation, fitted size, centering offsets and scale reciprocals.
// One shared radix-2 divider is sequenced over three divisions. Depends on lrns_pkg.
module lrns_geom (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  lrns_pkg::csr_regs_type cfg,
   output lrns_pkg::geom_type     geom
);

   lrns_pkg::geom_state_type state_ff, state_in;

   logic                            rot_c, wide_c, zero_c;
   logic [lrns_pkg::DIM_W-1:0]      ew_c, eh_c;
   logic [lrns_pkg::LADDR_W-1:0]    prod_a, prod_b;
   logic [lrns_pkg::DIM_W-1:0]      pw_q, ph_q;

   logic                            rot_ff, wide_ff, empty_ff;
   logic [lrns_pkg::DIM_W-1:0]      ew_ff, eh_ff, pw_ff, ph_ff, ox_ff, oy_ff;
   logic [lrns_pkg::RECIP_W-1:0]    rw_ff, rh_ff;

   // divider
   logic                            div_load;
   logic [lrns_pkg::RECIP_W-1:0]    div_num_ld;
   logic [lrns_pkg::DIM_W-1:0]      div_den_ld;
   logic [lrns_pkg::RECIP_W-1:0]    div_num_ff;
   logic [lrns_pkg::DIM_W-1:0]      div_den_ff;
   logic [lrns_pkg::DIM_W-1:0]      div_rem_ff;
   logic [lrns_pkg::DIV_CNT_W-1:0]  div_cnt_ff;
   logic [lrns_pkg::DIM_W:0]        div_rem_sh;
   logic                            div_bit;
   logic                            div_idle;

   assign div_idle   = (div_cnt_ff == '0);
   assign div_rem_sh = {div_rem_ff, div_num_ff[lrns_pkg::RECIP_W-1]};
   assign div_bit    = (div_rem_sh >= {1'b0, div_den_ff});

   always_comb begin
      rot_c  = (cfg.sw > cfg.sh) && (cfg.dw < cfg.dh);
      ew_c   = rot_c ? cfg.sh : cfg.sw;
      eh_c   = rot_c ? cfg.sw : cfg.sh;
      prod_a = cfg.dh * ew_c;
      prod_b = cfg.dw * eh_c;
      wide_c = (prod_a < prod_b);
      zero_c = (cfg.sw == '0) || (cfg.sh == '0) || (cfg.dw == '0) || (cfg.dh == '0);
      pw_q   = wide_ff ? div_num_ff[lrns_pkg::DIM_W-1:0] : cfg.dw;
      ph_q   = wide_ff ? cfg.dh : div_num_ff[lrns_pkg::DIM_W-1:0];

      state_in   = state_ff;
      div_load   = 1'b0;
      div_num_ld = '0;
      div_den_ld = '0;
      unique case (state_ff)
         lrns_pkg::G_SETUP: begin
            if (zero_c) begin
               state_in = lrns_pkg::G_DONE;
            end else begin
               div_load   = 1'b1;
               div_num_ld = wide_c ? lrns_pkg::RECIP_W'(prod_a) : lrns_pkg::RECIP_W'(prod_b);
               div_den_ld = wide_c ? eh_c : ew_c;
               state_in   = lrns_pkg::G_DIV_P;
            end
         end
         lrns_pkg::G_DIV_P: begin
            if (div_idle) begin
               if ((pw_q == '0) || (ph_q == '0)) begin
                  state_in = lrns_pkg::G_DONE;
               end else begin
                  div_load   = 1'b1;
                  div_num_ld = lrns_pkg::RECIP_ONE;
                  div_den_ld = pw_q;
                  state_in   = lrns_pkg::G_DIV_RW;
               end
            end
         end
         lrns_pkg::G_DIV_RW: begin
            if (div_idle) begin
               div_load   = 1'b1;
               div_num_ld = lrns_pkg::RECIP_ONE;
               div_den_ld = ph_ff;
               state_in   = lrns_pkg::G_DIV_RH;
            end
         end
         lrns_pkg::G_DIV_RH: begin
            if (div_idle) begin
               state_in = lrns_pkg::G_DONE;
            end
         end
         lrns_pkg::G_DONE: begin
            state_in = lrns_pkg::G_DONE;
         end
         default: begin
            state_in = lrns_pkg::G_SETUP;
         end
      endcase
      if (restart) begin
         state_in = lrns_pkg::G_SETUP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lrns_pkg::G_SETUP;
         div_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (div_load) begin
            div_cnt_ff <= lrns_pkg::DIV_CNT_W'(lrns_pkg::RECIP_W);
         end else if (!div_idle) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
      end
   end

   // restoring divide, one quotient bit per cycle; quotient shifts into the numerator
   always_ff @(posedge clock) begin
      if (div_load) begin
         div_num_ff <= div_num_ld;
         div_den_ff <= div_den_ld;
         div_rem_ff <= '0;
      end else if (!div_idle) begin
         div_num_ff <= {div_num_ff[lrns_pkg::RECIP_W-2:0], div_bit};
         if (div_bit) begin
            div_rem_ff <= lrns_pkg::DIM_W'(div_rem_sh - {1'b0, div_den_ff});
         end else begin
            div_rem_ff <= div_rem_sh[lrns_pkg::DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == lrns_pkg::G_SETUP) begin
         rot_ff   <= rot_c;
         ew_ff    <= ew_c;
         eh_ff    <= eh_c;
         wide_ff  <= wide_c;
         empty_ff <= zero_c;
      end
      if ((state_ff == lrns_pkg::G_DIV_P) && div_idle) begin
         pw_ff    <= pw_q;
         ph_ff    <= ph_q;
         empty_ff <= (pw_q == '0) || (ph_q == '0);
      end
      if ((state_ff == lrns_pkg::G_DIV_RW) && div_idle) begin
         rw_ff <= div_num_ff;
      end
      if ((state_ff == lrns_pkg::G_DIV_RH) && div_idle) begin
         rh_ff <= div_num_ff;
         ox_ff <= (cfg.dw - pw_ff) >> 1;
         oy_ff <= (cfg.dh - ph_ff) >> 1;
      end
   end

   always_comb begin
      geom.ready = (state_ff == lrns_pkg::G_DONE);
      geom.empty = empty_ff;
      geom.rot   = rot_ff;
      geom.ew    = ew_ff;
      geom.eh    = eh_ff;
      geom.pw    = pw_ff;
      geom.ph    = ph_ff;
      geom.ox    = ox_ff;
      geom.oy    = oy_ff;
      geom.rw    = rw_ff;
      geom.rh    = rh_ff;
   end

endmodule

// ===== tb/sv/letterbox_rotate_nearest_scaler_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for letterbox_rotate_nearest_scaler: random request traffic
// under several geometries, checked against an in-bench pixel predictor.
// Depends on lrns_pkg, lrns_if and the scaler RTL.
module letterbox_rotate_nearest_scaler_tb;

   localparam int FRAME_DEPTH     = 524288;
   localparam int NUM_PHASES      = 11;
   localparam int ITEMS_PER_PHASE = 78;
   localparam int CYCLE_LIMIT     = 400000;

   localparam int DIM_W   = lrns_pkg::DIM_W;
   localparam int PIX_W   = lrns_pkg::PIX_W;
   localparam int WADDR_W = lrns_pkg::WADDR_W;

   typedef struct packed {
      logic               func;
      logic [WADDR_W-1:0] write_address;
      logic [PIX_W-1:0]   write_value;
      logic [DIM_W-1:0]   display_x;
      logic [DIM_W-1:0]   display_y;
   } pixel_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             in_picture;
   } pixel_rsp_type;

   logic clock;
   logic reset;

   lrns_req_if req_bus ();
   lrns_rsp_if rsp_bus ();
   lrns_csr_if csr_bus ();

   letterbox_rotate_nearest_scaler #(
      .MAX_SOURCE_PIXELS(FRAME_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus),
      .csr  (csr_bus)
   );

   pixel_req_type          pending_reqs[$];
   pixel_rsp_type          expected_pixels[$];
   logic [PIX_W-1:0]       frame_copy [FRAME_DEPTH];
   bit                     frame_loaded [FRAME_DEPTH];
   lrns_pkg::csr_regs_type model_cfg;
   logic                   req_taken;
   int                     send_idle_pct;
   int                     recv_idle_pct;
   int                     mismatch_count;
   int                     cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Map a display coordinate to a linear source address under a given geometry.
   function automatic void locate_source(input lrns_pkg::csr_regs_type cfg,
                                         input logic [DIM_W-1:0] x,
                                         input logic [DIM_W-1:0] y,
                                         output logic hit,
                                         output int unsigned addr);
      int unsigned sw, sh, dw, dh, ew, eh, pw, ph, ox, oy, u, v, rx, ry, sx, sy;
      logic rot;
      sw = cfg.sw;
      sh = cfg.sh;
      dw = cfg.dw;
      dh = cfg.dh;
      hit = 1'b0;
      addr = 0;
      if (sw == 0 || sh == 0 || dw == 0 || dh == 0)
         return;
      rot = (sw > sh) && (dw < dh);
      ew = rot ? sh : sw;
      eh = rot ? sw : sh;
      if (dh * ew < dw * eh) begin
         ph = dh;
         pw = (ew * dh) / eh;
      end else begin
         pw = dw;
         ph = (eh * dw) / ew;
      end
      ox = (dw - pw) / 2;
      oy = (dh - ph) / 2;
      if (x < ox || y < oy)
         return;
      u = x - ox;
      v = y - oy;
      if (u >= pw || v >= ph)
         return;
      rx = (u * ew) / pw;
      ry = (v * eh) / ph;
      if (rot) begin
         sx = ry;
         sy = sh - 1 - rx;
      end else begin
         sx = rx;
         sy = ry;
      end
      hit = 1'b1;
      addr = sy * sw + sx;
   endfunction

   function automatic pixel_rsp_type predict_pixel(input pixel_req_type item);
      pixel_rsp_type r;
      logic          hit;
      int unsigned   addr;
      r.pixel_value = '0;
      r.in_picture = 1'b0;
      if (item.func == lrns_pkg::FUNC_WRITE) begin
         if (item.write_address < FRAME_DEPTH)
            frame_copy[item.write_address] = item.write_value;
         return r;
      end
      locate_source(model_cfg, item.display_x, item.display_y, hit, addr);
      r.in_picture = hit;
      r.pixel_value = (hit && addr < FRAME_DEPTH) ? frame_copy[addr] : lrns_pkg::WHITE;
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] pick_coord(input int unsigned span);
      case ($urandom_range(0, 9))
         0: return DIM_W'($urandom);
         1: return (span == 0) ? '0 : DIM_W'(span - 1);
         2: return DIM_W'(span);
         3: return '0;
         default: return (span == 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(0, span - 1));
      endcase
   endfunction

   task automatic queue_write(input logic [WADDR_W-1:0] addr, input logic [PIX_W-1:0] value);
      pixel_req_type item;
      item.func = lrns_pkg::FUNC_WRITE;
      item.write_address = addr;
      item.write_value = value;
      item.display_x = DIM_W'($urandom);
      item.display_y = DIM_W'($urandom);
      if (addr < FRAME_DEPTH)
         frame_loaded[addr] = 1'b1;
      pending_reqs.push_back(item);
   endtask

   // Load the source pixel first when it was never written, sometimes even when it was.
   task automatic queue_read(input lrns_pkg::csr_regs_type cfg, input logic [DIM_W-1:0] x,
                             input logic [DIM_W-1:0] y);
      pixel_req_type item;
      logic          hit;
      int unsigned   addr;
      locate_source(cfg, x, y, hit, addr);
      if (hit && addr < FRAME_DEPTH && (!frame_loaded[addr] || $urandom_range(0, 3) == 0))
         queue_write(WADDR_W'(addr), PIX_W'($urandom));
      item.func = lrns_pkg::FUNC_READ;
      item.write_address = WADDR_W'($urandom);
      item.write_value = PIX_W'($urandom);
      item.display_x = x;
      item.display_y = y;
      pending_reqs.push_back(item);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || expected_pixels.size() != 0);
   endtask

   task automatic write_register(input lrns_pkg::csr_index_type idx,
                                 input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   always @(negedge clock) begin : request_driver
      pixel_req_type item;
      logic          hold;
      hold = req_bus.valid && !req_taken;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!hold) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            item = pending_reqs.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.func <= item.func;
            req_bus.write_address <= item.write_address;
            req_bus.write_value <= item.write_value;
            req_bus.display_x <= item.display_x;
            req_bus.display_y <= item.display_y;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      rsp_bus.ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : pixel_monitor
      pixel_req_type item;
      pixel_rsp_type want;
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (reset) begin
         model_cfg <= '{sw: lrns_pkg::SRC_W_RESET, sh: lrns_pkg::SRC_H_RESET,
                        dw: lrns_pkg::DISP_W_RESET, dh: lrns_pkg::DISP_H_RESET};
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (lrns_pkg::csr_index_type'(csr_bus.index))
               lrns_pkg::CSR_SOURCE_WIDTH:   model_cfg.sw <= csr_bus.data;
               lrns_pkg::CSR_SOURCE_HEIGHT:  model_cfg.sh <= csr_bus.data;
               lrns_pkg::CSR_DISPLAY_WIDTH:  model_cfg.dw <= csr_bus.data;
               lrns_pkg::CSR_DISPLAY_HEIGHT: model_cfg.dh <= csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            item.func = req_bus.func;
            item.write_address = req_bus.write_address;
            item.write_value = req_bus.write_value;
            item.display_x = req_bus.display_x;
            item.display_y = req_bus.display_y;
            expected_pixels.push_back(predict_pixel(item));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected response transaction: pixel_value %0d in_picture %0d",
                      rsp_bus.pixel_value, rsp_bus.in_picture);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_bus.pixel_value !== want.pixel_value) begin
                  $error("pixel_value expected %0d got %0d", want.pixel_value,
                         rsp_bus.pixel_value);
                  mismatch_count++;
               end
               if (rsp_bus.in_picture !== want.in_picture) begin
                  $error("in_picture expected %0d got %0d", want.in_picture,
                         rsp_bus.in_picture);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("letterbox_rotate_nearest_scaler_tb NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      lrns_pkg::csr_regs_type plan [NUM_PHASES];
      lrns_pkg::csr_regs_type phase_cfg;
      int unsigned            addr;
      int                     p;
      int                     mode;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = lrns_pkg::FUNC_WRITE;
      req_bus.write_address = '0;
      req_bus.write_value = '0;
      req_bus.display_x = '0;
      req_bus.display_y = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = lrns_pkg::CSR_SOURCE_WIDTH;
      csr_bus.data = '0;
      req_taken = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      send_idle_pct = 38;
      recv_idle_pct = 58;

      plan[0]  = '{sw: lrns_pkg::SRC_W_RESET, sh: lrns_pkg::SRC_H_RESET,
                   dw: lrns_pkg::DISP_W_RESET, dh: lrns_pkg::DISP_H_RESET};
      plan[1]  = '{sw: 12'd4095, sh: 12'd4095, dw: 12'd4095, dh: 12'd4095};
      plan[2]  = '{sw: 12'd1, sh: 12'd1, dw: 12'd1, dh: 12'd1};
      plan[3]  = '{sw: 12'd0, sh: 12'd480, dw: 12'd1072, dh: 12'd1448};
      plan[4]  = '{sw: 12'd4095, sh: 12'd1, dw: 12'd1, dh: 12'd2};
      plan[5]  = '{sw: 12'd100, sh: 12'd300, dw: 12'd800, dh: 12'd600};
      plan[6]  = '{sw: 12'd1000, sh: 12'd10, dw: 12'd64, dh: 12'd4095};
      plan[7]  = '{sw: 12'd37, sh: 12'd23, dw: 12'd200, dh: 12'd60};
      plan[8]  = '{sw: 12'($urandom_range(1, 200)), sh: 12'($urandom_range(1, 200)),
                   dw: 12'($urandom_range(1, 300)), dh: 12'($urandom_range(1, 300))};
      plan[9]  = '{sw: 12'($urandom_range(1, 4095)), sh: 12'($urandom_range(1, 4095)),
                   dw: 12'($urandom_range(1, 4095)), dh: 12'($urandom_range(1, 4095))};
      plan[10] = '{sw: 12'd5, sh: 12'd0, dw: 12'd300, dh: 12'd0};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (p = 0; p < NUM_PHASES; p++) begin
         phase_cfg = plan[p];
         mode = p * 3 / NUM_PHASES;
         send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 58 : 0;
         recv_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 38 : 0;
         if (p != 0) begin
            write_register(lrns_pkg::CSR_SOURCE_WIDTH, phase_cfg.sw);
            write_register(lrns_pkg::CSR_SOURCE_HEIGHT, phase_cfg.sh);
            write_register(lrns_pkg::CSR_DISPLAY_WIDTH, phase_cfg.dw);
            write_register(lrns_pkg::CSR_DISPLAY_HEIGHT, phase_cfg.dh);
         end else begin
            // Reset geometry is rotated: picture 1072 x 1429, rows 9 to 1437.
            queue_write('0, 8'h00);
            queue_write('1, 8'hFF);
            queue_write(19'h55555, 8'hAA);
            queue_read(phase_cfg, 12'd0, 12'd0);
            queue_read(phase_cfg, 12'd0, 12'd9);
            queue_read(phase_cfg, 12'd1071, 12'd9);
            queue_read(phase_cfg, 12'd0, 12'd1437);
            queue_read(phase_cfg, 12'd1071, 12'd1437);
            queue_read(phase_cfg, 12'd536, 12'd724);
            queue_read(phase_cfg, 12'd1071, 12'd1438);
            queue_read(phase_cfg, 12'd1072, 12'd9);
            queue_read(phase_cfg, 12'd4095, 12'd4095);
         end

         // Count the pixel loads that reads pull in as well.
         while (pending_reqs.size() < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 65) begin
               queue_read(phase_cfg, pick_coord(phase_cfg.dw), pick_coord(phase_cfg.dh));
            end else begin
               addr = $urandom_range(0, FRAME_DEPTH - 1);
               if ($urandom_range(0, 1) == 0 && phase_cfg.sw != 0 && phase_cfg.sh != 0) begin
                  addr = $urandom_range(0, phase_cfg.sh - 1) * phase_cfg.sw
                         + $urandom_range(0, phase_cfg.sw - 1);
                  if (addr >= FRAME_DEPTH)
                     addr = $urandom_range(0, FRAME_DEPTH - 1);
               end
               queue_write(WADDR_W'(addr), PIX_W'($urandom));
            end
         end
         wait_idle();
      end

      // Let any stray response show up before the verdict.
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("letterbox_rotate_nearest_scaler_tb OK");
      else
         $display("letterbox_rotate_nearest_scaler_tb NOT OK");
      $finish;
   end

endmodule
